// ----- rtl/bmpg_pkg.sv -----
// Shared types, constants and codes for the BMP sheet to glyph row converter.
package bmpg_pkg;

   // Sheet geometry and header layout
   localparam int unsigned SheetSide    = 128;
   localparam int unsigned MaxRowLen    = 132;
   localparam int unsigned HeaderLen    = 54;
   localparam int unsigned MinDibSize   = 40;
   localparam int unsigned RspFifoDepth = 8;

   localparam logic [7:0] MagicFirst  = 8'h42;
   localparam logic [7:0] MagicSecond = 8'h4D;

   // Padded row length and pixel data length per depth
   localparam int unsigned Stride1    = ((SheetSide * 1 + 31) / 32) * 4;
   localparam int unsigned Stride4    = ((SheetSide * 4 + 31) / 32) * 4;
   localparam int unsigned Stride8    = ((SheetSide * 8 + 31) / 32) * 4;
   localparam int unsigned DataBytes1 = SheetSide * 1 / 8;
   localparam int unsigned DataBytes4 = SheetSide * 4 / 8;
   localparam int unsigned DataBytes8 = SheetSide * 8 / 8;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_SKIP   = 2'd1,
      PH_PIXELS = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK             = 3'd0,
      ST_NOT_BMP        = 3'd1,
      ST_BAD_HEADER     = 3'd2,
      ST_WRONG_SIZE     = 3'd3,
      ST_BAD_DEPTH      = 3'd4,
      ST_TRUNCATED      = 3'd5,
      ST_OFFSET_OVERLAP = 3'd6
   } status_type;

   typedef enum logic {
      KIND_ROW    = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type   item_kind;
      logic [7:0] glyph_code;
      logic [2:0] glyph_line;
      logic [7:0] glyph_bits;
      status_type load_status;
      logic       final_item;
   } result_type;

   // Up to two result words produced by one input word, in order
   typedef struct packed {
      logic       first_valid;
      logic       second_valid;
      result_type first;
      result_type second;
   } push_type;

endpackage

// ----- rtl/bmpg_req_if.sv -----
// Input channel: one byte of the BMP file per word.
interface bmpg_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_file;

   modport source (output valid, output data_byte, output end_of_file, input ready);
   modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

// ----- rtl/bmpg_rsp_if.sv -----
// Result channel: glyph row writes and the final load status.
interface bmpg_rsp_if;
   logic       valid;
   logic       ready;
   logic       item_kind;
   logic [7:0] glyph_code;
   logic [2:0] glyph_line;
   logic [7:0] glyph_bits;
   logic [2:0] load_status;
   logic       final_item;

   modport source (output valid, output item_kind, output glyph_code, output glyph_line,
                   output glyph_bits, output load_status, output final_item, input ready);
   modport sink   (input valid, input item_kind, input glyph_code, input glyph_line,
                   input glyph_bits, input load_status, input final_item, output ready);
endinterface

// ----- rtl/bmpg_parser.sv -----
// Header parser and pixel unpacker: one file byte per cycle, up to two results.
module bmpg_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  logic [7:0]        data_byte,
   input  logic              end_of_file,
   output bmpg_pkg::push_type push
);

   localparam logic [31:0] HeightUp   = 32'(bmpg_pkg::SheetSide);
   localparam logic [31:0] HeightDown = 32'd0 - HeightUp;
   localparam logic        Depth1Fits = (bmpg_pkg::Stride1 <= bmpg_pkg::MaxRowLen);
   localparam logic        Depth4Fits = (bmpg_pkg::Stride4 <= bmpg_pkg::MaxRowLen);
   localparam logic        Depth8Fits = (bmpg_pkg::Stride8 <= bmpg_pkg::MaxRowLen);

   bmpg_pkg::phase_type phase_ff, phase_in, phase_mid;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] offset_ff, offset_in;
   logic [31:0] dib_ff, dib_in;
   logic [31:0] width_ff, width_in;
   logic [31:0] height_ff, height_in;
   logic [15:0] depth_ff, depth_in;
   logic [31:0] comp_ff, comp_in;
   logic        magic_ff, magic_in;
   logic [7:0]  rows_ff, rows_in;
   logic [7:0]  bir_ff, bir_in;
   logic [7:0]  acc_ff, acc_in;
   logic [2:0]  cnt_ff, cnt_in;

   bmpg_pkg::status_type hdr_status;
   logic        depth_ok;
   logic [5:0]  hdr_pos;
   logic [1:0]  lane;
   logic [7:0]  stride;
   logic [7:0]  data_bytes;
   logic [7:0]  acc_new;
   logic [3:0]  npix;
   logic [3:0]  cnt_sum;
   logic [3:0]  x_group;
   logic [6:0]  glyph_y;
   logic [7:0]  bir_next;
   logic [7:0]  rows_next;

   // Candidate results in model order: glyph row, phase status, end of file status
   logic                 row_valid, stat_valid, eof_valid;
   bmpg_pkg::result_type row_item, stat_item, eof_item;

   function automatic bmpg_pkg::result_type status_item(input bmpg_pkg::status_type s);
      bmpg_pkg::result_type r;
      r.item_kind   = bmpg_pkg::KIND_STATUS;
      r.glyph_code  = 8'd0;
      r.glyph_line  = 3'd0;
      r.glyph_bits  = 8'd0;
      r.load_status = s;
      r.final_item  = 1'b1;
      return r;
   endfunction

   assign hdr_pos = pos_ff[5:0];

   always_comb begin
      depth_ok = ((depth_ff == 16'd1) && Depth1Fits) ||
                 ((depth_ff == 16'd4) && Depth4Fits) ||
                 ((depth_ff == 16'd8) && Depth8Fits);
      hdr_status = bmpg_pkg::ST_OK;
      if (!magic_ff) begin
         hdr_status = bmpg_pkg::ST_NOT_BMP;
      end else if (dib_ff < 32'(bmpg_pkg::MinDibSize) || comp_ff != 32'd0) begin
         hdr_status = bmpg_pkg::ST_BAD_HEADER;
      end else if (width_ff != HeightUp || !(height_ff == HeightUp || height_ff == HeightDown)) begin
         hdr_status = bmpg_pkg::ST_WRONG_SIZE;
      end else if (!depth_ok) begin
         hdr_status = bmpg_pkg::ST_BAD_DEPTH;
      end else if (offset_ff < 32'(bmpg_pkg::HeaderLen)) begin
         hdr_status = bmpg_pkg::ST_OFFSET_OVERLAP;
      end
   end

   // Per-depth row geometry and pixel packing
   always_comb begin
      case (depth_ff)
         16'd1: begin
            stride     = 8'(bmpg_pkg::Stride1);
            data_bytes = 8'(bmpg_pkg::DataBytes1);
            npix       = 4'd8;
            acc_new    = data_byte;
            x_group    = bir_ff[3:0];
         end
         16'd4: begin
            stride     = 8'(bmpg_pkg::Stride4);
            data_bytes = 8'(bmpg_pkg::DataBytes4);
            npix       = 4'd2;
            acc_new    = {acc_ff[5:0], |data_byte[7:4], |data_byte[3:0]};
            x_group    = bir_ff[5:2];
         end
         default: begin
            stride     = 8'(bmpg_pkg::Stride8);
            data_bytes = 8'(bmpg_pkg::DataBytes8);
            npix       = 4'd1;
            acc_new    = {acc_ff[6:0], |data_byte};
            x_group    = bir_ff[6:3];
         end
      endcase
      cnt_sum   = {1'b0, cnt_ff} + npix;
      glyph_y   = height_ff[31] ? rows_ff[6:0] : (7'(bmpg_pkg::SheetSide - 1) - rows_ff[6:0]);
      bir_next  = bir_ff + 8'd1;
      rows_next = rows_ff + 8'd1;
   end

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      offset_in = offset_ff;
      dib_in    = dib_ff;
      width_in  = width_ff;
      height_in = height_ff;
      depth_in  = depth_ff;
      comp_in   = comp_ff;
      magic_in  = magic_ff;
      rows_in   = rows_ff;
      bir_in    = bir_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      lane      = 2'd0;

      row_valid  = 1'b0;
      stat_valid = 1'b0;
      eof_valid  = 1'b0;
      row_item.item_kind   = bmpg_pkg::KIND_ROW;
      row_item.glyph_code  = {glyph_y[6:3], x_group};
      row_item.glyph_line  = glyph_y[2:0];
      row_item.glyph_bits  = acc_new;
      row_item.load_status = bmpg_pkg::ST_OK;
      row_item.final_item  = 1'b0;
      stat_item = status_item(hdr_status);
      eof_item  = status_item(bmpg_pkg::ST_NOT_BMP);

      if (item_valid) begin
         case (phase_ff)
            bmpg_pkg::PH_HEADER: begin
               // Header bytes arrive once each after a clear, so drop them into lanes
               case (hdr_pos) inside
                  6'd0: magic_in = (data_byte == bmpg_pkg::MagicFirst);
                  6'd1: magic_in = magic_ff && (data_byte == bmpg_pkg::MagicSecond);
                  [6'd10:6'd13]: begin
                     lane = 2'(hdr_pos - 6'd10);
                     offset_in[{lane, 3'b000} +: 8] = data_byte;
                  end
                  [6'd14:6'd17]: begin
                     lane = 2'(hdr_pos - 6'd14);
                     dib_in[{lane, 3'b000} +: 8] = data_byte;
                  end
                  [6'd18:6'd21]: begin
                     lane = 2'(hdr_pos - 6'd18);
                     width_in[{lane, 3'b000} +: 8] = data_byte;
                  end
                  [6'd22:6'd25]: begin
                     lane = 2'(hdr_pos - 6'd22);
                     height_in[{lane, 3'b000} +: 8] = data_byte;
                  end
                  [6'd28:6'd29]: begin
                     lane = 2'(hdr_pos - 6'd28);
                     depth_in[{lane[0], 3'b000} +: 8] = data_byte;
                  end
                  [6'd30:6'd33]: begin
                     lane = 2'(hdr_pos - 6'd30);
                     comp_in[{lane, 3'b000} +: 8] = data_byte;
                  end
                  default: ;
               endcase
               if (hdr_pos == 6'(bmpg_pkg::HeaderLen - 1)) begin
                  if (hdr_status != bmpg_pkg::ST_OK) begin
                     stat_valid = 1'b1;
                     phase_in   = bmpg_pkg::PH_DONE;
                  end else if (offset_ff == 32'(bmpg_pkg::HeaderLen)) begin
                     phase_in = bmpg_pkg::PH_PIXELS;
                  end else begin
                     phase_in = bmpg_pkg::PH_SKIP;
                  end
               end
            end
            bmpg_pkg::PH_SKIP: begin
               if ((pos_ff + 32'd1) >= offset_ff) begin
                  phase_in = bmpg_pkg::PH_PIXELS;
               end
            end
            bmpg_pkg::PH_PIXELS: begin
               if (bir_ff < data_bytes) begin
                  if (cnt_sum[3]) begin
                     row_valid = 1'b1;
                     acc_in    = 8'd0;
                     cnt_in    = 3'd0;
                  end else begin
                     acc_in = acc_new;
                     cnt_in = cnt_sum[2:0];
                  end
               end
               bir_in = bir_next;
               // Row padding done: restart the row and count it
               if (bir_next >= stride) begin
                  bir_in  = 8'd0;
                  acc_in  = 8'd0;
                  cnt_in  = 3'd0;
                  rows_in = rows_next;
                  if (rows_next >= 8'(bmpg_pkg::SheetSide)) begin
                     stat_valid = 1'b1;
                     stat_item  = status_item(bmpg_pkg::ST_OK);
                     phase_in   = bmpg_pkg::PH_DONE;
                  end
               end
            end
            default: ;
         endcase

         if (pos_ff != 32'hFFFF_FFFF) begin
            pos_in = pos_ff + 32'd1;
         end

         if (end_of_file) begin
            case (phase_in)
               bmpg_pkg::PH_HEADER: begin
                  eof_valid = 1'b1;
               end
               bmpg_pkg::PH_SKIP, bmpg_pkg::PH_PIXELS: begin
                  eof_valid = 1'b1;
                  eof_item  = status_item(bmpg_pkg::ST_TRUNCATED);
               end
               default: ;
            endcase
            phase_in  = bmpg_pkg::PH_HEADER;
            pos_in    = 32'd0;
            offset_in = 32'd0;
            dib_in    = 32'd0;
            width_in  = 32'd0;
            height_in = 32'd0;
            depth_in  = 16'd0;
            comp_in   = 32'd0;
            magic_in  = 1'b0;
            rows_in   = 8'd0;
            bir_in    = 8'd0;
            acc_in    = 8'd0;
            cnt_in    = 3'd0;
         end
      end
   end

   assign phase_mid = phase_in;

   // Pack candidates into the first and second slot, keeping order
   always_comb begin
      push.first_valid  = row_valid || stat_valid || eof_valid;
      push.second_valid = (row_valid && (stat_valid || eof_valid)) || (stat_valid && eof_valid);
      if (row_valid) begin
         push.first  = row_item;
         push.second = stat_valid ? stat_item : eof_item;
      end else if (stat_valid) begin
         push.first  = stat_item;
         push.second = eof_item;
      end else begin
         push.first  = eof_item;
         push.second = eof_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= bmpg_pkg::PH_HEADER;
         pos_ff    <= 32'd0;
         offset_ff <= 32'd0;
         dib_ff    <= 32'd0;
         width_ff  <= 32'd0;
         height_ff <= 32'd0;
         depth_ff  <= 16'd0;
         comp_ff   <= 32'd0;
         magic_ff  <= 1'b0;
         rows_ff   <= 8'd0;
         bir_ff    <= 8'd0;
         acc_ff    <= 8'd0;
         cnt_ff    <= 3'd0;
      end else begin
         phase_ff  <= phase_mid;
         pos_ff    <= pos_in;
         offset_ff <= offset_in;
         dib_ff    <= dib_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         depth_ff  <= depth_in;
         comp_ff   <= comp_in;
         magic_ff  <= magic_in;
         rows_ff   <= rows_in;
         bir_ff    <= bir_in;
         acc_ff    <= acc_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ----- rtl/bmpg_result_fifo.sv -----
// Result queue: takes up to two words per cycle, gives one per cycle when pop is asserted.
module bmpg_result_fifo #(
   parameter int unsigned DEPTH = bmpg_pkg::RspFifoDepth  // at least 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  bmpg_pkg::push_type      push,
   input  logic                    pop,
   output bmpg_pkg::result_type    head,
   output logic                    not_empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int unsigned PW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   bmpg_pkg::result_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in, wr_second;
   logic [CW-1:0] count_ff, count_in;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] ptr);
      return (ptr == PW'(DEPTH - 1)) ? '0 : ptr + PW'(1);
   endfunction

   always_comb begin
      wr_second = next_ptr(wr_ff);
      wr_in     = wr_ff;
      if (push.first_valid && push.second_valid) begin
         wr_in = next_ptr(wr_second);
      end else if (push.first_valid) begin
         wr_in = wr_second;
      end
      rd_in    = pop ? next_ptr(rd_ff) : rd_ff;
      count_in = count_ff + CW'(push.first_valid) + CW'(push.second_valid) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         if (push.first_valid && wr_ff == PW'(i)) begin
            entry_ff[i] <= push.first;
         end else if (push.second_valid && wr_second == PW'(i)) begin
            entry_ff[i] <= push.second;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   assign head      = entry_ff[rd_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

endmodule

// ----- rtl/bmp_sheet_to_glyph_rows_top.sv -----
// BMP font sheet to 8x8 glyph rows: top level with input stage and result queue.
// Data path: a file byte is registered in the input stage, parsed combinationally, and its
//   result words are written into the result queue, from which they are offered.
// Throughput: one file byte per cycle while the result side drains; a byte that
//   causes two words (end of sheet or end of file) queues both, drained one word at a time.
// Input is held off when the result queue lacks room for two more words per byte in flight.
// Reset (synchronous): parser state, input stage valid flag and queue pointers clear at once.
module bmp_sheet_to_glyph_rows_top #(
   parameter int unsigned RSP_FIFO_DEPTH = bmpg_pkg::RspFifoDepth
) (
   input  logic         clock,
   input  logic         reset,
   bmpg_req_if.sink     req_ch,
   bmpg_rsp_if.source   rsp_ch
);

   localparam int unsigned CW = $clog2(RSP_FIFO_DEPTH + 1);

   logic       stage_valid_ff, stage_valid_in;
   logic [7:0] stage_byte_ff;
   logic       stage_eof_ff;
   logic       req_accept;
   logic       rsp_pop;
   logic [CW+1:0] room_need;

   bmpg_pkg::push_type   push;
   bmpg_pkg::result_type head;
   logic                 not_empty;
   logic [CW-1:0]        count;

   // Worst case: queued words, two from the staged byte, two from the new one
   assign room_need    = (CW+2)'(count) + (stage_valid_ff ? (CW+2)'(4) : (CW+2)'(2));
   assign req_ch.ready = (room_need <= (CW+2)'(RSP_FIFO_DEPTH));
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign stage_valid_in = req_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_byte_ff <= req_ch.data_byte;
         stage_eof_ff  <= req_ch.end_of_file;
      end
   end

   bmpg_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (stage_valid_ff),
      .data_byte   (stage_byte_ff),
      .end_of_file (stage_eof_ff),
      .push        (push)
   );

   assign rsp_pop = not_empty && rsp_ch.ready;

   bmpg_result_fifo #(
      .DEPTH (RSP_FIFO_DEPTH)
   ) u_result_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_pop),
      .head      (head),
      .not_empty (not_empty),
      .count     (count)
   );

   assign rsp_ch.valid       = not_empty;
   assign rsp_ch.item_kind   = head.item_kind;
   assign rsp_ch.glyph_code  = head.glyph_code;
   assign rsp_ch.glyph_line  = head.glyph_line;
   assign rsp_ch.glyph_bits  = head.glyph_bits;
   assign rsp_ch.load_status = head.load_status;
   assign rsp_ch.final_item  = head.final_item;

endmodule

// ----- rtl/bmpg_checker.sv -----
// Port-level checks for the glyph row converter, bound to the top level.
module bmpg_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       item_kind,
   input logic [7:0] glyph_code,
   input logic [2:0] glyph_line,
   input logic [7:0] glyph_bits,
   input logic [2:0] load_status,
   input logic       final_item
);

   // Nothing left over in the queue after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word offered right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({item_kind, glyph_code, glyph_line, glyph_bits, load_status, final_item}))
      else $error("stalled result word changed");

   a_row_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && item_kind == bmpg_pkg::KIND_ROW |->
         !final_item && load_status == bmpg_pkg::ST_OK)
      else $error("glyph row word carries status fields");

   a_status_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && item_kind == bmpg_pkg::KIND_STATUS |->
         final_item && glyph_code == 8'd0 && glyph_line == 3'd0 && glyph_bits == 8'd0)
      else $error("status word carries glyph fields");

endmodule

bind bmp_sheet_to_glyph_rows_top bmpg_checker u_bmpg_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .item_kind   (rsp_ch.item_kind),
   .glyph_code  (rsp_ch.glyph_code),
   .glyph_line  (rsp_ch.glyph_line),
   .glyph_bits  (rsp_ch.glyph_bits),
   .load_status (rsp_ch.load_status),
   .final_item  (rsp_ch.final_item)
);
